// ===== rtl/quadrature_position_counter_unit_defines.svh =====
// Assertion macros for the quadrature position counter.
`ifndef QUADRATURE_POSITION_COUNTER_UNIT_DEFINES_SVH
`define QUADRATURE_POSITION_COUNTER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked on every rising edge out of reset
`define QPC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("qpc: same-cycle check failed");
// next-cycle implication
`define QPC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("qpc: next-cycle check failed");
`else
`define QPC_ASSERT_NOW(label, ante, cons)
`define QPC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/qpc_pkg.sv =====
// Shared constants, types and the quadrature step table.
`default_nettype none
package qpc_pkg;

   localparam int COUNT_W    = 32;             // raw count width
   localparam int DET_W      = 21;             // detent position width
   localparam int STEP_W     = 7;              // steps per detent width
   localparam int OFS_W      = 8;              // count offset width
   localparam int REQ_TYPE_W = 2;
   localparam int MUL_W      = DET_W + STEP_W + 1;
   localparam int QUO_W      = COUNT_W + 1;    // signed quotient of a full count
   localparam int CSR_AW     = 5;
   localparam int CSR_DW     = 32;
   localparam int REG_IDX_W  = CSR_AW - 2;

   // request codes
   localparam logic [REQ_TYPE_W-1:0] REQ_PIN = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_SET = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_CLR = 2'd2;

   // register indexes
   localparam logic [REG_IDX_W-1:0] REG_MIN_DET  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_MAX_DET  = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_WRAP_EN  = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_STEPS    = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_OFFSET   = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_COUNT_EN = 3'd5;

   typedef struct packed {
      logic                       start;
      logic signed [COUNT_W-1:0]  dividend;
      logic [STEP_W-1:0]          divisor;
   } div_cmd_type;

   typedef struct packed {
      logic                       busy;
      logic                       done;
      logic signed [QUO_W-1:0]    quotient;
   } div_res_type;

   // 4x decode: previous AB pair in [3:2], current pair in [1:0]
   function automatic logic signed [1:0] qpc_step(input logic [3:0] hist);
      logic signed [1:0] s;
      unique case (hist) inside
         4'd1, 4'd7, 4'd8, 4'd14:  s = -2'sd1;
         4'd2, 4'd4, 4'd11, 4'd13: s = 2'sd1;
         default:                  s = 2'sd0;
      endcase
      return s;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/qpc_if.sv =====
// Request and response channel interfaces.
`default_nettype none
interface qpc_req_if import qpc_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [REQ_TYPE_W-1:0]   req_type;
   logic                    pin_a;
   logic                    pin_b;
   logic signed [DET_W-1:0] new_value;

   modport source (output valid, req_type, pin_a, pin_b, new_value, input ready);
   modport sink   (input valid, req_type, pin_a, pin_b, new_value, output ready);
endinterface

interface qpc_rsp_if import qpc_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [DET_W-1:0]   position;
   logic signed [COUNT_W-1:0] raw_count;

   modport source (output valid, position, raw_count, input ready);
   modport sink   (input valid, position, raw_count, output ready);
endinterface
`default_nettype wire

// ===== rtl/qpc_div.sv =====
// Bit-serial signed-by-unsigned divider, truncating towards zero.
`default_nettype none
module qpc_div import qpc_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  div_cmd_type cmd,
   output div_res_type res
);

   localparam int CNT_W = $clog2(COUNT_W);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [COUNT_W-1:0] dvd_ff, dvd_in;   // magnitude in, quotient out
   logic [STEP_W-1:0]  rem_ff, rem_in;
   logic [STEP_W-1:0]  dsr_ff, dsr_in;
   logic               neg_ff, neg_in;

   logic [STEP_W:0]    trial;
   logic [STEP_W:0]    diff;
   logic               fits;
   logic [QUO_W-1:0]   mag;

   assign trial = {rem_ff, dvd_ff[COUNT_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = (trial >= {1'b0, dsr_ff});
   assign mag   = {1'b0, dvd_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      neg_in  = neg_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         neg_in  = cmd.dividend[COUNT_W-1];
         dvd_in  = cmd.dividend[COUNT_W-1] ? COUNT_W'(-cmd.dividend) : COUNT_W'(cmd.dividend);
         rem_in  = '0;
         dsr_in  = cmd.divisor;
      end else if (busy_ff) begin
         // one quotient bit per cycle; remainder stays below the divisor
         rem_in = fits ? diff[STEP_W-1:0] : trial[STEP_W-1:0];
         dvd_in = {dvd_ff[COUNT_W-2:0], fits};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(COUNT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      neg_ff <= neg_in;
   end

   assign res.busy     = busy_ff;
   assign res.done     = done_ff;
   assign res.quotient = neg_ff ? -$signed(mag) : $signed(mag);

endmodule
`default_nettype wire

// ===== rtl/quadrature_position_counter_unit.sv =====
// Quadrature position counter: 4x decode, detent limits, clamp or wrap.
//
//  channel  | role   | moves                                      | handshake
//  ---------+--------+--------------------------------------------+-----------------
//  req_chan | sink   | request item: req_type, pin_a/b, new_value | valid/ready
//  rsp_chan | source | result item: position, raw_count           | valid/ready
//  csr_*    | slave  | six limit/mode registers, 4-byte stride    | APB, pready tied
//
// Every item uses the shared 21x7 multiplier for each product it needs
// (the limits and, on a set value, the loaded value) and then the
// bit-serial divider by steps per detent; a pin sample that wraps past a
// limit takes a second pass of the divider. One item is in the block at
// a time; req_chan.ready is high only in idle. The result register lets
// the next item in while the last result waits. Reset is synchronous and
// clears history and count.
`default_nettype none
`include "quadrature_position_counter_unit_defines.svh"
module quadrature_position_counter_unit import qpc_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   qpc_req_if.sink                req_chan,
   qpc_rsp_if.source              rsp_chan,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   output logic      [CSR_DW-1:0] csr_prdata,
   output logic                   csr_pready
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_MIN,
      ST_MUL_MAX,
      ST_MUL_NV,
      ST_LOAD,
      ST_DIV,
      ST_WAIT,
      ST_FIX,
      ST_OUT
   } state_type;

   // ---------------------------------------------------------------- registers
   logic signed [DET_W-1:0] min_ff;
   logic signed [DET_W-1:0] max_ff;
   logic                    wrap_ff;
   logic [STEP_W-1:0]       steps_ff;
   logic signed [OFS_W-1:0] ofs_ff;
   logic                    cnt_en_ff;

   logic [REG_IDX_W-1:0]    csr_idx;
   logic                    csr_wr;
   logic [STEP_W-1:0]       steps_eff;

   assign csr_idx    = csr_paddr[CSR_AW-1:2];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   // a zero step count behaves as one
   assign steps_eff  = (steps_ff == '0) ? STEP_W'(1) : steps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff    <= {1'b1, {(DET_W-1){1'b0}}};
         max_ff    <= {1'b0, {(DET_W-1){1'b1}}};
         wrap_ff   <= 1'b0;
         steps_ff  <= STEP_W'(1);
         ofs_ff    <= '0;
         cnt_en_ff <= 1'b1;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_MIN_DET:  min_ff    <= csr_pwdata[DET_W-1:0];
            REG_MAX_DET:  max_ff    <= csr_pwdata[DET_W-1:0];
            REG_WRAP_EN:  wrap_ff   <= csr_pwdata[0];
            REG_STEPS:    steps_ff  <= csr_pwdata[STEP_W-1:0];
            REG_OFFSET:   ofs_ff    <= csr_pwdata[OFS_W-1:0];
            REG_COUNT_EN: cnt_en_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_MIN_DET:  csr_prdata = CSR_DW'(min_ff);
         REG_MAX_DET:  csr_prdata = CSR_DW'(max_ff);
         REG_WRAP_EN:  csr_prdata = CSR_DW'(wrap_ff);
         REG_STEPS:    csr_prdata = CSR_DW'(steps_ff);
         REG_OFFSET:   csr_prdata = CSR_DW'(ofs_ff);
         REG_COUNT_EN: csr_prdata = CSR_DW'(cnt_en_ff);
         default:      csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- datapath
   state_type                 state_ff, state_in;
   logic [3:0]                hist_ff, hist_in;
   logic signed [COUNT_W-1:0] raw_ff, raw_in;
   logic signed [COUNT_W-1:0] work_ff, work_in;   // candidate count / dividend
   logic signed [COUNT_W-1:0] rep_ff, rep_in;     // count before read-and-reset
   logic [REQ_TYPE_W-1:0]     type_ff, type_in;
   logic signed [DET_W-1:0]   nv_ff, nv_in;
   logic signed [MUL_W-1:0]   minr_ff, minr_in;
   logic signed [MUL_W-1:0]   maxr_ff, maxr_in;
   logic signed [MUL_W-1:0]   prod_ff, prod_in;
   logic signed [QUO_W-1:0]   q_ff, q_in;
   logic                      chk_ff, chk_in;     // divide is the limit check
   logic                      over_ff, over_in;
   logic                      under_ff, under_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [DET_W-1:0]   rsp_pos_ff, rsp_pos_in;
   logic signed [COUNT_W-1:0] rsp_raw_ff, rsp_raw_in;

   // shared multiplier: limits and loaded value, scaled to raw counts
   logic signed [DET_W-1:0]   mul_a;
   logic signed [MUL_W-1:0]   mul_p;
   assign mul_p = MUL_W'(mul_a * $signed({1'b0, steps_eff}));

   logic signed [COUNT_W-1:0] minr_w, maxr_w, steps_w;
   logic signed [COUNT_W-1:0] ld_v, ld_a, ld_b;
   logic signed [QUO_W-1:0]   min_q, max_q;
   logic signed [DET_W-1:0]   pos_w;
   logic                      out_load;

   div_cmd_type div_cmd;
   div_res_type div_res;

   assign minr_w  = COUNT_W'(minr_ff);
   assign maxr_w  = COUNT_W'(maxr_ff);
   assign steps_w = $signed({{(COUNT_W-STEP_W){1'b0}}, steps_eff});
   assign min_q   = QUO_W'(min_ff);
   assign max_q   = QUO_W'(max_ff);

   // load path: above max first, then below min, as separate checks
   assign ld_v = (type_ff == REQ_SET) ? (COUNT_W'(prod_ff) + COUNT_W'(ofs_ff))
                                      : COUNT_W'(ofs_ff);
   assign ld_a = (ld_v > maxr_w) ? (wrap_ff ? minr_w : maxr_w) : ld_v;
   assign ld_b = (ld_a < minr_w) ? (wrap_ff ? maxr_w : minr_w) : ld_a;

   // reported detent position, clamped
   always_comb begin
      if (q_ff > max_q) begin
         pos_w = max_ff;
      end else if (q_ff < min_q) begin
         pos_w = min_ff;
      end else begin
         pos_w = q_ff[DET_W-1:0];
      end
   end

   assign out_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_chan.ready);

   assign div_cmd.start    = (state_ff == ST_DIV);
   assign div_cmd.dividend = work_ff;
   assign div_cmd.divisor  = steps_eff;

   qpc_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .res   (div_res)
   );

   assign req_chan.ready     = (state_ff == ST_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.position  = rsp_pos_ff;
   assign rsp_chan.raw_count = rsp_raw_ff;

   always_comb begin
      state_in     = state_ff;
      hist_in      = hist_ff;
      raw_in       = raw_ff;
      work_in      = work_ff;
      rep_in       = rep_ff;
      type_in      = type_ff;
      nv_in        = nv_ff;
      minr_in      = minr_ff;
      maxr_in      = maxr_ff;
      prod_in      = prod_ff;
      q_in         = q_ff;
      chk_in       = chk_ff;
      over_in      = over_ff;
      under_in     = under_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_raw_in   = rsp_raw_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      mul_a        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               type_in = req_chan.req_type;
               nv_in   = req_chan.new_value;
               rep_in  = raw_ff;
               if ((req_chan.req_type == REQ_PIN) && cnt_en_ff) begin
                  // shift the new AB pair in and step the count
                  hist_in = {hist_ff[1:0], req_chan.pin_b, req_chan.pin_a};
                  work_in = raw_ff + COUNT_W'(qpc_step(hist_in));
                  chk_in  = 1'b1;
               end else begin
                  work_in = raw_ff;
                  chk_in  = 1'b0;
               end
               state_in = ST_MUL_MIN;
            end
         end
         ST_MUL_MIN: begin
            mul_a    = min_ff;
            minr_in  = mul_p;
            state_in = ST_MUL_MAX;
         end
         ST_MUL_MAX: begin
            mul_a   = max_ff;
            maxr_in = mul_p;
            if (type_ff == REQ_SET) begin
               state_in = ST_MUL_NV;
            end else if (type_ff == REQ_CLR) begin
               state_in = ST_LOAD;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_MUL_NV: begin
            mul_a    = nv_ff;
            prod_in  = mul_p;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            raw_in   = ld_b;
            work_in  = ld_b;
            chk_in   = 1'b0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_res.done) begin
               q_in = div_res.quotient;
               if (chk_ff) begin
                  over_in  = (div_res.quotient > max_q);
                  under_in = (div_res.quotient < min_q);
                  if ((div_res.quotient > max_q) || (div_res.quotient < min_q)) begin
                     state_in = ST_FIX;
                  end else begin
                     raw_in   = work_ff;
                     state_in = ST_OUT;
                  end
               end else begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_FIX: begin
            if (over_ff) begin
               if (wrap_ff) begin
                  raw_in   = minr_w + work_ff - maxr_w - steps_w;
                  work_in  = minr_w + work_ff - maxr_w - steps_w;
                  chk_in   = 1'b0;
                  state_in = ST_DIV;
               end else begin
                  raw_in   = maxr_w;
                  q_in     = max_q;
                  state_in = ST_OUT;
               end
            end else begin
               if (wrap_ff) begin
                  raw_in   = maxr_w + work_ff - minr_w + steps_w;
                  work_in  = maxr_w + work_ff - minr_w + steps_w;
                  chk_in   = 1'b0;
                  state_in = ST_DIV;
               end else begin
                  raw_in   = minr_w;
                  q_in     = min_q;
                  state_in = ST_OUT;
               end
            end
         end
         ST_OUT: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               rsp_pos_in   = pos_w;
               rsp_raw_in   = (type_ff == REQ_CLR) ? rep_ff : raw_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hist_ff      <= '0;
         raw_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hist_ff      <= hist_in;
         raw_ff       <= raw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      work_ff    <= work_in;
      rep_ff     <= rep_in;
      type_ff    <= type_in;
      nv_ff      <= nv_in;
      minr_ff    <= minr_in;
      maxr_ff    <= maxr_in;
      prod_ff    <= prod_in;
      q_ff       <= q_in;
      chk_ff     <= chk_in;
      over_ff    <= over_in;
      under_ff   <= under_in;
      rsp_pos_ff <= rsp_pos_in;
      rsp_raw_ff <= rsp_raw_in;
   end

   // ---------------------------------------------------------------- checks
   `QPC_ASSERT_NEXT(a_one_item, req_chan.valid && req_chan.ready, !req_chan.ready)
   `QPC_ASSERT_NOW(a_div_start_idle, div_cmd.start, !div_res.busy)
   `QPC_ASSERT_NOW(a_div_done_wait, div_res.done, state_ff == ST_WAIT)
   `QPC_ASSERT_NOW(a_pos_in_range, out_load && (min_ff <= max_ff), (pos_w >= min_ff) && (pos_w <= max_ff))

endmodule
`default_nettype wire

// ===== tb/sv/tb_quadrature_position_counter_unit.sv =====
// Self-checking testbench for the quadrature position counter unit.
`default_nettype none
module tb_quadrature_position_counter_unit;
   import qpc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD    = 10;
   localparam int RESET_CYCLES  = 9;
   localparam int CYCLE_LIMIT   = 1_000_000;  // well above the slowest run
   localparam int TAIL_CYCLES   = 100;        // beyond the wrap-pass latency of the block
   localparam int HOLD_CYCLES   = 400;        // long output hold-off
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 250;
   localparam int MAX_REPORTS   = 10;

   // request code the block leaves unnamed
   localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;

   // 4x decode, indexed by {previous AB, current AB}
   localparam int QUAD_DELTA [16] = '{0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0};
   // next AB pair for one count up / one count down
   localparam logic [1:0] FWD_NEXT [4] = '{2'd2, 2'd0, 2'd3, 2'd1};
   localparam logic [1:0] BWD_NEXT [4] = '{2'd1, 2'd3, 2'd0, 2'd2};

   typedef struct {
      logic [REQ_TYPE_W-1:0]   kind;
      logic                    pin_a;
      logic                    pin_b;
      logic signed [DET_W-1:0] new_value;
   } request_t;

   typedef struct {
      logic signed [DET_W-1:0]   position;
      logic signed [COUNT_W-1:0] raw_count;
   } reading_t;

   logic clock = 1'b0;
   logic reset;

   qpc_req_if req_chan ();
   qpc_rsp_if rsp_chan ();

   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   quadrature_position_counter_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor: own copy of the register settings and the counter state
   // ---------------------------------------------------------------------
   logic signed [DET_W-1:0]   lim_min;
   logic signed [DET_W-1:0]   lim_max;
   logic                      wrap_en;
   logic [STEP_W-1:0]         steps_cfg;
   logic signed [OFS_W-1:0]   offset_cfg;
   logic                      count_en;
   logic [3:0]                pin_hist;
   logic signed [COUNT_W-1:0] count_q;

   request_t pending_requests [$];   // items waiting for the driver
   reading_t expected_readings [$];  // predicted results, oldest first

   int  n_errors = 0;
   int  n_checked = 0;
   int  n_settings = 0;
   int  n_kind [4] = '{0, 0, 0, 0};
   int  gap_left = 0;
   int  stall_left = 0;
   int  hold_left = 0;
   int  hold_seen = 0;
   int  hold_request = 0;
   int  cycle_count = 0;
   logic quiet = 1'b0;               // no idling on either side once set

   request_t   offered;
   logic [1:0] last_ab = 2'd0;       // last AB pair sent, for well-formed turns
   int         turn_dir = 1;

   // Loaded values: above the top limit first, then below the bottom one.
   function automatic void load_raw(input longint v, input longint min_raw,
                                    input longint max_raw);
      if (v > max_raw) v = wrap_en ? min_raw : max_raw;
      if (v < min_raw) v = wrap_en ? max_raw : min_raw;
      count_q = v;
   endfunction

   function automatic reading_t step_counter(input request_t rq);
      longint steps, min_raw, max_raw, t, c, q;
      logic signed [COUNT_W-1:0] sum, shown;
      reading_t r;
      steps   = (steps_cfg == '0) ? 1 : longint'(steps_cfg);  // zero acts as one
      min_raw = longint'(lim_min) * steps;
      max_raw = longint'(lim_max) * steps;
      shown   = count_q;
      case (rq.kind)
         REQ_PIN: begin
            if (count_en) begin
               pin_hist = {pin_hist[1:0], rq.pin_b, rq.pin_a};
               sum = longint'(count_q) + QUAD_DELTA[pin_hist];
               t   = sum;
               q   = t / steps;
               // the lower wrap mirrors the upper one
               if (q > longint'(lim_max)) begin
                  c = wrap_en ? min_raw + (t - max_raw - steps) : max_raw;
               end else if (q < longint'(lim_min)) begin
                  c = wrap_en ? max_raw + (t - min_raw + steps) : min_raw;
               end else begin
                  c = t;
               end
               count_q = c;
            end
            shown = count_q;
         end
         REQ_SET: begin
            load_raw(longint'(rq.new_value) * steps + longint'(offset_cfg), min_raw, max_raw);
            shown = count_q;
         end
         REQ_CLR: begin
            // reports the count from before the reload
            load_raw(longint'(offset_cfg), min_raw, max_raw);
         end
         default: begin
         end
      endcase
      q = longint'(count_q) / steps;
      if (q > longint'(lim_max)) q = lim_max;
      else if (q < longint'(lim_min)) q = lim_min;
      r.position  = q;
      r.raw_count = shown;
      return r;
   endfunction

   function automatic void flag_error(input string msg);
      n_errors++;
      if (n_errors <= MAX_REPORTS) $display("ERROR: %s", msg);
   endfunction

   // ---------------------------------------------------------------------
   // Request driver: prediction happens at the edge that accepts an item
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : request_driver
      logic offer;
      if (reset) begin
         req_chan.valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            expected_readings.push_back(step_counter(offered));
            n_kind[offered.kind]++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            offer = 1'b0;
            if (gap_left != 0) begin
               gap_left--;
            end else if (pending_requests.size() != 0) begin
               // idle burst instead of the next item
               if (!quiet && $urandom_range(0, 99) < 12) begin
                  gap_left = $urandom_range(0, 2);
               end else begin
                  offered = pending_requests.pop_front();
                  offer = 1'b1;
               end
            end
            req_chan.valid     <= offer;
            req_chan.req_type  <= offered.kind;
            req_chan.pin_a     <= offered.pin_a;
            req_chan.pin_b     <= offered.pin_b;
            req_chan.new_value <= offered.new_value;
         end
      end
   end

   // long hold-off of the result side, counted here, started on request
   always @(posedge clock) begin : long_holdoff
      if (reset) begin
         hold_left <= 0;
         hold_seen <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_seen != hold_request) begin
         hold_left <= HOLD_CYCLES;
         hold_seen <= hold_request;
      end
   end

   // ---------------------------------------------------------------------
   // Result monitor: in-order compare against the predicted readings
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : reading_monitor
      reading_t got, want;
      logic     take;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.position  = rsp_chan.position;
            got.raw_count = rsp_chan.raw_count;
            n_checked++;
            if (expected_readings.size() == 0) begin
               flag_error($sformatf("reading with none expected: position %0d raw_count %0d",
                                    got.position, got.raw_count));
            end else begin
               want = expected_readings.pop_front();
               if (got.position !== want.position || got.raw_count !== want.raw_count) begin
                  flag_error($sformatf(
                     "reading %0d: position exp %0d got %0d, raw_count exp %0d got %0d",
                     n_checked, want.position, got.position, want.raw_count, got.raw_count));
               end
            end
         end
         take = 1'b1;
         if (hold_left != 0) begin
            take = 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            take = 1'b0;
         end else if (!quiet && $urandom_range(0, 99) < 12) begin
            stall_left = $urandom_range(0, 2);
            take = 1'b0;
         end
         rsp_chan.ready <= take;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      // written at this edge; pready is tied high
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_MIN_DET:  lim_min    = value[DET_W-1:0];
         REG_MAX_DET:  lim_max    = value[DET_W-1:0];
         REG_WRAP_EN:  wrap_en    = value[0];
         REG_STEPS:    steps_cfg  = value[STEP_W-1:0];
         REG_OFFSET:   offset_cfg = value[OFS_W-1:0];
         REG_COUNT_EN: count_en   = value[0];
         default: begin
         end
      endcase
   endtask

   task automatic set_config(input int lo, input int hi, input int wrap, input int steps,
                             input int ofs, input int en);
      write_reg(REG_MIN_DET, lo);
      write_reg(REG_MAX_DET, hi);
      write_reg(REG_WRAP_EN, wrap);
      write_reg(REG_STEPS, steps);
      write_reg(REG_OFFSET, ofs);
      write_reg(REG_COUNT_EN, en);
      n_settings++;
      @(negedge clock);
   endtask

   // block idle: nothing queued, nothing offered, nothing outstanding
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_requests.size() != 0 || req_chan.valid || expected_readings.size() != 0);
   endtask

   task automatic queue_request(input logic [REQ_TYPE_W-1:0] kind, input logic a,
                                input logic b, input logic signed [DET_W-1:0] nv);
      request_t rq;
      rq.kind      = kind;
      rq.pin_a     = a;
      rq.pin_b     = b;
      rq.new_value = nv;
      pending_requests.push_back(rq);
   endtask

   // new_value is don't-care on a pin sample, so it carries noise
   task automatic queue_pin(input logic [1:0] ab);
      queue_request(REQ_PIN, ab[0], ab[1], $urandom);
      last_ab = ab;
   endtask

   task automatic queue_turn(input int dir);
      queue_pin(dir > 0 ? FWD_NEXT[last_ab] : BWD_NEXT[last_ab]);
   endtask

   task automatic random_setting();
      int lo, hi, steps;
      case ($urandom_range(0, 5))
         0: begin lo = -1048576; hi = 1048575; end
         1: begin lo = -int'($urandom_range(0, 20)); hi = $urandom_range(0, 20); end
         2: begin lo = $urandom_range(1, 10); hi = -int'($urandom_range(0, 10)); end
         3: begin lo = $urandom; hi = $urandom; end
         default: begin lo = -int'($urandom_range(1, 6)); hi = $urandom_range(0, 6); end
      endcase
      case ($urandom_range(0, 4))
         0:       steps = 0;
         1:       steps = 1;
         2:       steps = $urandom_range(2, 8);
         3:       steps = $urandom_range(9, 127);
         default: steps = $urandom_range(0, 127);
      endcase
      set_config(lo, hi, $urandom_range(0, 1), steps, $urandom_range(0, 255),
                 $urandom_range(0, 7) != 0);
   endtask

   // Mostly well-formed turns in runs, plus loads, clears and noise.
   task automatic queue_random(input int n);
      int r, base;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            if ($urandom_range(0, 9) == 0) turn_dir = -turn_dir;
            queue_turn(turn_dir);
         end else if (r < 78) begin
            queue_pin($urandom_range(0, 3));
         end else if (r < 88) begin
            if ($urandom_range(0, 1) != 0) begin
               // land close to a limit so the turns cross it
               base = ($urandom_range(0, 1) != 0) ? int'(lim_min) : int'(lim_max);
               queue_request(REQ_SET, $urandom, $urandom, base + int'($urandom_range(0, 6)) - 3);
            end else begin
               queue_request(REQ_SET, $urandom, $urandom, $urandom);
            end
         end else if (r < 94) begin
            queue_request(REQ_CLR, $urandom, $urandom, $urandom);
         end else if (r < 97) begin
            queue_request(REQ_UNUSED, $urandom, $urandom, $urandom);
         end else begin
            queue_request($urandom_range(0, 3), $urandom, $urandom, $urandom);
         end
      end
   endtask

   // walk covering all sixteen history values from a cleared history
   localparam logic [1:0] PIN_WALK [16] =
      '{2'd0, 2'd1, 2'd0, 2'd2, 2'd0, 2'd3, 2'd1, 2'd1,
        2'd2, 2'd1, 2'd3, 2'd2, 2'd2, 2'd3, 2'd3, 2'd0};

   // ---------------------------------------------------------------------
   // Sequence of the run
   // ---------------------------------------------------------------------
   initial begin : stimulus
      int phase;
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.req_type  = REQ_PIN;
      req_chan.pin_a     = 1'b0;
      req_chan.pin_b     = 1'b0;
      req_chan.new_value = '0;
      rsp_chan.ready     = 1'b0;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      offered            = '{REQ_PIN, 1'b0, 1'b0, '0};
      // state and settings after reset
      lim_min    = -21'sd1048576;
      lim_max    = 21'sd1048575;
      wrap_en    = 1'b0;
      steps_cfg  = 7'd1;
      offset_cfg = '0;
      count_en   = 1'b1;
      pin_hist   = '0;
      count_q    = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: every history value, loads at the field extremes,
      // read-and-reset and the unused request code
      foreach (PIN_WALK[i]) queue_pin(PIN_WALK[i]);
      queue_request(REQ_SET, 1'b0, 1'b0, -21'sd1048576);
      queue_request(REQ_SET, 1'b1, 1'b1, 21'sd1048575);
      queue_request(REQ_CLR, 1'b0, 1'b1, '0);
      queue_request(REQ_UNUSED, 1'b1, 1'b0, -21'sd1);
      wait_idle();

      // tight limits with wrap, steps of zero, top offset:
      // wrap up past the maximum, wrap down past the minimum, over-range load
      set_config(-2, 2, 1, 0, 127, 1);
      queue_request(REQ_SET, 1'b0, 1'b0, -21'sd125);
      queue_turn(1);
      queue_turn(1);
      queue_turn(-1);
      queue_turn(-1);
      queue_turn(-1);
      queue_request(REQ_SET, 1'b0, 1'b0, 21'sd5);
      queue_request(REQ_CLR, 1'b0, 1'b0, '0);
      wait_idle();

      // counting off, steps at the top, bottom offset, minimum above maximum
      set_config(3, -3, 0, 127, -128, 0);
      queue_turn(1);
      queue_request(REQ_SET, 1'b0, 1'b0, '0);
      queue_request(REQ_SET, 1'b0, 1'b0, -21'sd1048576);
      queue_request(REQ_CLR, 1'b0, 1'b0, '0);
      queue_request(REQ_UNUSED, 1'b0, 1'b0, '0);
      wait_idle();

      // random phases, each under a fresh setting, block idle in between
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         random_setting();
         if (phase == RANDOM_PHASES - 1) quiet <= 1'b1;
         // hold results back long enough that the input stalls
         if (phase == 3) hold_request <= hold_request + 1;
         queue_random(PHASE_ITEMS);
         wait_idle();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_readings.size() != 0)
         flag_error($sformatf("%0d readings never arrived", expected_readings.size()));

      $display("Covered %0d pin samples, %0d set-value, %0d read-and-reset, %0d unused-code items",
               n_kind[REQ_PIN], n_kind[REQ_SET], n_kind[REQ_CLR], n_kind[REQ_UNUSED]);
      $display("over %0d register settings; %0d readings checked, %0d errors",
               n_settings, n_checked, n_errors);
      if (n_errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // watchdog on the cycle count
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
   end

endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/qpc_pkg.sv
rtl/qpc_if.sv
rtl/qpc_div.sv
rtl/quadrature_position_counter_unit.sv
tb/sv/tb_quadrature_position_counter_unit.sv
